>>> rtl/core/hdlctx_pkg.sv
package hdlctx_pkg;

  localparam int BYTE_W = 8;
  localparam int CRC_W  = 16;
  localparam int SCR_W  = 17;
  localparam int RUN_W  = 3;
  localparam int SEG_W  = 10;
  localparam int LEN_W  = 4;
  localparam int ACC_W  = SEG_W + BYTE_W;
  localparam int CNT_W  = 5;

  localparam int SCR_TAP_A = 16;
  localparam int SCR_TAP_B = 11;

  localparam logic [BYTE_W-1:0] FLAG_PATTERN = 8'h7E;
  localparam logic [CRC_W-1:0]  CRC_POLY     = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_INIT     = 16'hFFFF;
  localparam logic [RUN_W-1:0]  STUFF_RUN    = 3'd5;

  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 3;
  localparam int REG_IDX_W = CFG_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_LINE_MODE = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCR_SEED  = 1'd1;

  localparam int SEG_Q_DEPTH_DEF = 2;
  localparam int OUT_Q_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_FLAG  = 2'd1,
    OP_DATA  = 2'd2,
    OP_END   = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              frame_last;
  } out_item_t;

  // line bits of one byte after stuffing, first bit in the top position
  typedef struct packed {
    logic [SEG_W-1:0] bits;
    logic [LEN_W-1:0] len;
    logic             restart;
    logic             seg_last;
    logic             is_end;
  } seg_t;

  typedef struct packed {
    logic             line_mode;
    logic [SCR_W-1:0] scrambler_seed;
  } cfg_t;

endpackage

>>> rtl/core/hdlctx_queue.sv
module hdlctx_queue #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_item,
  output logic  full,
  input  logic  pop,
  output item_t rd_item,
  output logic  empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

>>> rtl/core/hdlctx_cfg.sv
module hdlctx_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hdlctx_pkg::CFG_AW-1:0]      paddr,
  input  logic [hdlctx_pkg::CFG_DW-1:0]      pwdata,
  output logic [hdlctx_pkg::CFG_DW-1:0]      prdata,
  output logic                               pready,
  output hdlctx_pkg::cfg_t                   cfg
);
  import hdlctx_pkg::*;

  logic             line_mode_r;
  logic [SCR_W-1:0] seed_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_LINE_MODE: prdata = CFG_DW'(line_mode_r);
      REG_SCR_SEED:  prdata = CFG_DW'(seed_r);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_mode_r <= 1'b0;
      seed_r      <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LINE_MODE: line_mode_r <= pwdata[0];
        REG_SCR_SEED:  seed_r      <= pwdata[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.line_mode      = line_mode_r;
  assign cfg.scrambler_seed = seed_r;

endmodule

>>> rtl/core/hdlctx_stuff.sv
module hdlctx_stuff (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  hdlctx_pkg::in_item_t in_item,
  output logic                 in_full,
  output logic                 seg_push,
  output hdlctx_pkg::seg_t     seg_item,
  input  logic                 seg_full
);
  import hdlctx_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_CRC_LO = 3'b010,
    PH_FLAG   = 3'b100
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [RUN_W-1:0]  ones_r, ones_nxt;
  logic              accept, stuff_en;
  logic [BYTE_W-1:0] raw, sh;
  logic [RUN_W-1:0]  ones_run;
  logic [SEG_W-1:0]  bits;
  logic [LEN_W-1:0]  pos;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int j = 0; j < BYTE_W; j++) begin
      c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
    end
    return c;
  endfunction

  always_comb begin
    in_full   = seg_full || (phase_r != PH_IDLE);
    accept    = in_push && !in_full;
    raw       = FLAG_PATTERN;
    stuff_en  = 1'b0;
    crc_nxt   = crc_r;
    phase_nxt = phase_r;
    seg_push  = 1'b0;
    seg_item.restart  = 1'b0;
    seg_item.seg_last = 1'b1;
    seg_item.is_end   = 1'b0;

    unique case (phase_r)
      PH_CRC_LO: begin
        raw               = crc_r[BYTE_W-1:0];
        stuff_en          = 1'b1;
        seg_item.seg_last = 1'b0;
        seg_item.is_end   = 1'b1;
        seg_push          = !seg_full;
        if (!seg_full) begin
          phase_nxt = PH_FLAG;
        end
      end
      PH_FLAG: begin
        seg_item.is_end = 1'b1;
        seg_push        = !seg_full;
        if (!seg_full) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_IDLE: begin
        seg_push = accept;
        unique case (in_item.op)
          OP_START: begin
            seg_item.restart = 1'b1;
            if (accept) begin
              crc_nxt = CRC_INIT;
            end
          end
          OP_FLAG: ;
          OP_DATA: begin
            raw      = in_item.data_byte;
            stuff_en = 1'b1;
            if (accept) begin
              crc_nxt = crc_byte(crc_r, in_item.data_byte);
            end
          end
          OP_END: begin
            raw               = crc_r[CRC_W-1:BYTE_W];
            stuff_en          = 1'b1;
            seg_item.seg_last = 1'b0;
            seg_item.is_end   = 1'b1;
            if (accept) begin
              phase_nxt = PH_CRC_LO;
            end
          end
          default: ;
        endcase
      end
      default: phase_nxt = PH_IDLE;
    endcase

    // zero inserted after five ones; inserted bits are already zero in bits
    bits     = '0;
    pos      = '0;
    sh       = raw;
    ones_run = ones_r;
    for (int i = 0; i < BYTE_W; i++) begin
      bits[LEN_W'(SEG_W - 1) - pos] = sh[BYTE_W-1];
      pos = pos + LEN_W'(1);
      if (stuff_en) begin
        if (sh[BYTE_W-1]) begin
          ones_run = ones_run + RUN_W'(1);
          if (ones_run >= STUFF_RUN) begin
            pos      = pos + LEN_W'(1);
            ones_run = '0;
          end
        end else begin
          ones_run = '0;
        end
      end
      sh = sh << 1;
    end
    if (!stuff_en) begin
      ones_run = '0;
    end

    seg_item.bits = bits;
    seg_item.len  = pos;
    ones_nxt      = seg_push ? ones_run : ones_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      crc_r   <= CRC_INIT;
      ones_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      ones_r  <= ones_nxt;
    end
  end

endmodule

>>> rtl/core/hdlctx_code.sv
module hdlctx_code (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hdlctx_pkg::cfg_t      cfg,
  input  logic                  seg_empty,
  input  hdlctx_pkg::seg_t      seg_item,
  output logic                  seg_pop,
  output logic                  out_push,
  output hdlctx_pkg::out_item_t out_item,
  input  logic                  out_full
);
  import hdlctx_pkg::*;

  logic [ACC_W-1:0] acc_r, acc_nxt, acc_left;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_left, sum;
  logic             level_r, level_nxt, level;
  logic [SCR_W-1:0] scr_r, scr_nxt, scr;
  logic             tag_last_r, tag_last_nxt, tag_end_r, tag_end_nxt;
  logic             pop_byte, raw_bit, c;
  logic [SEG_W-1:0] sh, coded;

  always_comb begin
    pop_byte = (cnt_r >= CNT_W'(BYTE_W)) && !out_full;
    cnt_left = pop_byte ? cnt_r - CNT_W'(BYTE_W) : cnt_r;
    acc_left = pop_byte ? (acc_r << BYTE_W) : acc_r;
    seg_pop  = !seg_empty && (cnt_left < CNT_W'(BYTE_W));

    level = seg_item.restart ? 1'b0 : level_r;
    scr   = seg_item.restart ? cfg.scrambler_seed : scr_r;
    sh    = seg_item.bits;
    coded = '0;
    for (int i = 0; i < SEG_W; i++) begin
      raw_bit = sh[SEG_W-1];
      c       = 1'b0;
      if (LEN_W'(i) < seg_item.len) begin
        if (cfg.line_mode) begin
          c   = raw_bit ^ scr[SCR_TAP_A] ^ scr[SCR_TAP_B];
          scr = {scr[SCR_W-2:0], c};
        end else begin
          if (!raw_bit) begin
            level = ~level;
          end
          c = level;
        end
      end
      coded = {coded[SEG_W-2:0], c};
      sh    = sh << 1;
    end

    // closing flag: round up to a whole byte, pad bits stay zero
    sum = cnt_left + CNT_W'(seg_item.len);
    if (seg_item.is_end && seg_item.seg_last && (sum[2:0] != 3'd0)) begin
      sum = {sum[CNT_W-1:3] + (CNT_W-3)'(1), 3'd0};
    end

    acc_nxt      = acc_left;
    cnt_nxt      = cnt_left;
    level_nxt    = level_r;
    scr_nxt      = scr_r;
    tag_last_nxt = tag_last_r;
    tag_end_nxt  = tag_end_r;
    if (seg_pop) begin
      acc_nxt      = acc_left | ({coded, {BYTE_W{1'b0}}} >> cnt_left);
      cnt_nxt      = sum;
      level_nxt    = level;
      scr_nxt      = scr;
      tag_last_nxt = seg_item.seg_last;
      tag_end_nxt  = seg_item.is_end;
    end

    out_push            = pop_byte;
    out_item.out_byte   = acc_r[ACC_W-1 -: BYTE_W];
    out_item.run_last   = tag_last_r && (cnt_r < CNT_W'(2 * BYTE_W));
    out_item.frame_last = tag_last_r && (cnt_r < CNT_W'(2 * BYTE_W)) && tag_end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      cnt_r      <= '0;
      level_r    <= 1'b0;
      scr_r      <= '0;
      tag_last_r <= 1'b0;
      tag_end_r  <= 1'b0;
    end else begin
      acc_r      <= acc_nxt;
      cnt_r      <= cnt_nxt;
      level_r    <= level_nxt;
      scr_r      <= scr_nxt;
      tag_last_r <= tag_last_nxt;
      tag_end_r  <= tag_end_nxt;
    end
  end

endmodule

>>> rtl/core/hdlc_tx_framer_stuff_scramble.sv
// Throughput: while the segment queue has room the stuffer takes one item per cycle;
// an end-of-frame item emits three segments (CRC high, CRC low, closing flag) and
// blocks input meanwhile; while the output queue has room the coder/packer releases
// one byte per cycle, which sets the sustained rate (1 to 2 bytes per data item).
// Reset (synchronous, rst_n low): queues empty, CRC to 0xFFFF, stuffing, line,
// scrambler and packing state and both config registers to zero.
module hdlc_tx_framer_stuff_scramble #(
  parameter int SEG_Q_DEPTH = hdlctx_pkg::SEG_Q_DEPTH_DEF,
  parameter int OUT_Q_DEPTH = hdlctx_pkg::OUT_Q_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  hdlctx_pkg::in_item_t          in_item,
  output logic                          in_full,
  output logic                          out_empty,
  input  logic                          out_pop,
  output hdlctx_pkg::out_item_t         out_item,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [hdlctx_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [hdlctx_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [hdlctx_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import hdlctx_pkg::*;

  cfg_t      cfg;
  seg_t      seg_wr, seg_rd;
  logic      seg_push, seg_full, seg_pop, seg_empty;
  out_item_t res_wr;
  logic      res_push, res_full;

  hdlctx_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  hdlctx_stuff u_stuff (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .seg_push (seg_push),
    .seg_item (seg_wr),
    .seg_full (seg_full)
  );

  hdlctx_queue #(
    .item_t (seg_t),
    .DEPTH  (SEG_Q_DEPTH)
  ) u_seg_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (seg_push),
    .wr_item (seg_wr),
    .full    (seg_full),
    .pop     (seg_pop),
    .rd_item (seg_rd),
    .empty   (seg_empty)
  );

  hdlctx_code u_code (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .seg_empty (seg_empty),
    .seg_item  (seg_rd),
    .seg_pop   (seg_pop),
    .out_push  (res_push),
    .out_item  (res_wr),
    .out_full  (res_full)
  );

  hdlctx_queue #(
    .item_t (out_item_t),
    .DEPTH  (OUT_Q_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_item (res_wr),
    .full    (res_full),
    .pop     (out_pop),
    .rd_item (out_item),
    .empty   (out_empty)
  );

  a_seg_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    seg_push |-> !seg_full)
    else $error("segment pushed into full queue");

  a_res_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("results pending right after reset");

  a_frame_last_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.frame_last) |-> out_item.run_last)
    else $error("frame end item not marked as last of its run");

endmodule

>>> dv/hdlc_tx_framer_stuff_scramble_tb.sv
module hdlc_tx_framer_stuff_scramble_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hdlctx_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_LEN       = 120;
  localparam int DRAIN_CYCLES   = 10;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  in_item_t             in_item = '0;
  logic                 in_full;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  out_item_t            out_item;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]    cfg_paddr = '0;
  logic [CFG_DW-1:0]    cfg_pwdata = '0;
  logic [CFG_DW-1:0]    cfg_prdata;
  logic                 cfg_pready;

  hdlc_tx_framer_stuff_scramble dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_item    (in_item),
    .in_full    (in_full),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_item   (out_item),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // framer model state
  logic              line_mode_q = 1'b0;
  logic [SCR_W-1:0]  seed_q = '0;
  logic [CRC_W-1:0]  crc_acc = CRC_INIT;
  logic [RUN_W-1:0]  stuff_ones = '0;
  logic              nrzi_level = 1'b0;
  logic [SCR_W-1:0]  scr_state = '0;
  logic [BYTE_W-1:0] pack_byte = '0;
  logic [2:0]        pack_fill = '0;
  logic [BYTE_W-1:0] coded_bytes[$];
  out_item_t         expected_out[$];

  int  errors = 0;
  int  burst_left = 0;
  bit  tx_bursty = 1'b0;
  bit  rx_free = 1'b1;
  bit  hold_req = 1'b0;
  bit  hold_ack = 1'b0;
  int  hold_cnt = 0;
  int  rx_run = 0;
  out_item_t want_item;

  wire in_fire  = in_push && !in_full;
  wire out_fire = out_pop && !out_empty;
  wire cfg_fire = cfg_psel && cfg_penable && cfg_pready;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR @%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void code_bit(logic raw);
    logic c;
    if (line_mode_q) begin
      c = raw ^ scr_state[SCR_TAP_A] ^ scr_state[SCR_TAP_B];
      scr_state = {scr_state[SCR_W-2:0], c};
    end else begin
      if (!raw) nrzi_level = ~nrzi_level;
      c = nrzi_level;
    end
    pack_byte[3'd7 - pack_fill] = c;
    if (pack_fill == 3'd7) begin
      coded_bytes.push_back(pack_byte);
      pack_byte = '0;
      pack_fill = '0;
    end else begin
      pack_fill = pack_fill + 3'd1;
    end
  endfunction

  function automatic void send_flag_bits();
    for (int i = 7; i >= 0; i--) code_bit(FLAG_PATTERN[i]);
    stuff_ones = '0;
  endfunction

  function automatic void send_stuffed_bits(logic [BYTE_W-1:0] b);
    for (int i = 7; i >= 0; i--) begin
      code_bit(b[i]);
      if (b[i]) begin
        stuff_ones = stuff_ones + 3'd1;
        if (stuff_ones >= STUFF_RUN) begin
          code_bit(1'b0);
          stuff_ones = '0;
        end
      end else begin
        stuff_ones = '0;
      end
    end
  endfunction

  function automatic void crc_fold(logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_acc ^ {b, 8'h00};
    for (int j = 0; j < 8; j++) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    crc_acc = c;
  endfunction

  function automatic void frame_item(in_item_t it);
    logic [CRC_W-1:0] fcs;
    logic             last;
    coded_bytes.delete();
    case (it.op)
      OP_START: begin
        crc_acc    = CRC_INIT;
        stuff_ones = '0;
        nrzi_level = 1'b0;
        scr_state  = seed_q;
        send_flag_bits();
      end
      OP_FLAG: send_flag_bits();
      OP_DATA: begin
        crc_fold(it.data_byte);
        send_stuffed_bits(it.data_byte);
      end
      default: begin
        fcs = crc_acc;
        send_stuffed_bits(fcs[15:8]);
        send_stuffed_bits(fcs[7:0]);
        send_flag_bits();
        if (pack_fill != 0) begin
          coded_bytes.push_back(pack_byte);
          pack_byte = '0;
          pack_fill = '0;
        end
      end
    endcase
    for (int k = 0; k < coded_bytes.size(); k++) begin
      last = (k == coded_bytes.size() - 1);
      expected_out.push_back(out_item_t'{out_byte: coded_bytes[k], run_last: last,
                                         frame_last: last && (it.op == OP_END)});
    end
  endfunction

  task automatic send_item(op_t op, logic [BYTE_W-1:0] db);
    in_item_t it;
    it = '{op: op, data_byte: db};
    @(negedge clk);
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    frame_item(it);
  endtask

  task automatic send_paced(op_t op, logic [BYTE_W-1:0] db);
    int gap;
    if (tx_bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    send_item(op, db);
  endtask

  task automatic drain_wait();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_LINE_MODE) line_mode_q = val[0];
    else seed_q = val[SCR_W-1:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic cfg_read_check(logic [REG_IDX_W-1:0] idx);
    logic [CFG_DW-1:0] want;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    want = (idx == REG_LINE_MODE) ? CFG_DW'(line_mode_q) : CFG_DW'(seed_q);
    if (cfg_prdata !== want) report_mismatch("register readback", cfg_prdata, want);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_data();
    case ($urandom_range(0, 9))
      0, 1, 2: pick_data = 8'hFF;
      3:       pick_data = FLAG_PATTERN;
      4:       pick_data = 8'hF8 | 8'($urandom_range(0, 7));
      default: pick_data = 8'($urandom_range(0, 255));
    endcase
  endfunction

  // receiver: long hold-off once on request, else free running or random stalls
  always @(negedge clk) begin
    if (hold_req && !hold_ack) begin
      hold_ack <= 1'b1;
      hold_cnt <= HOLD_LEN;
      out_pop  <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_pop  <= 1'b0;
    end else if (rx_free) begin
      out_pop <= 1'b1;
    end else if (rx_run != 0) begin
      rx_run <= rx_run - 1;
    end else begin
      out_pop <= ~out_pop;
      rx_run  <= out_pop ? $urandom_range(0, 5) : $urandom_range(0, 10);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_fire) begin
      if (expected_out.size() == 0) begin
        report_mismatch("unexpected item", 32'(out_item), 32'd0);
      end else begin
        want_item = expected_out.pop_front();
        if (out_item.out_byte !== want_item.out_byte)
          report_mismatch("out_byte", 32'(out_item.out_byte), 32'(want_item.out_byte));
        if (out_item.run_last !== want_item.run_last)
          report_mismatch("run_last", 32'(out_item.run_last), 32'(want_item.run_last));
        if (out_item.frame_last !== want_item.frame_last)
          report_mismatch("frame_last", 32'(out_item.frame_last),
                          32'(want_item.frame_last));
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (in_fire || out_fire || cfg_fire) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("ERROR @%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic test_ops_without_start();
    send_item(OP_DATA, 8'hAA);
    send_item(OP_FLAG, 8'h00);
    send_item(OP_END, 8'hFF);
    drain_wait();
  endtask

  task automatic test_register_access();
    cfg_read_check(REG_LINE_MODE);
    cfg_read_check(REG_SCR_SEED);
    cfg_write(REG_LINE_MODE, 32'd0);
    cfg_write(REG_SCR_SEED, 32'h1FFFF);
    cfg_read_check(REG_LINE_MODE);
    cfg_read_check(REG_SCR_SEED);
  endtask

  task automatic test_nrzi_frame();
    send_item(OP_START, 8'h00);
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_DATA, 8'h1F);
    send_item(OP_DATA, 8'hF8);
    send_item(OP_DATA, 8'h7E);
    send_item(OP_END, 8'h00);
    drain_wait();
  endtask

  task automatic test_scrambler_frame();
    cfg_write(REG_LINE_MODE, 32'd1);
    cfg_read_check(REG_LINE_MODE);
    send_item(OP_START, 8'hFF);
    send_item(OP_DATA, 8'h55);
    send_item(OP_FLAG, 8'hFF);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_END, 8'h00);
    // partial byte left by the stuffed data, then a restart
    send_item(OP_DATA, 8'hFF);
    send_item(OP_START, 8'h00);
    send_item(OP_DATA, 8'h81);
    send_item(OP_END, 8'hFF);
    drain_wait();
  endtask

  task automatic test_mode_change_mid_frame();
    cfg_write(REG_LINE_MODE, 32'd0);
    send_item(OP_START, 8'h00);
    send_item(OP_DATA, 8'hFF);
    drain_wait();
    cfg_write(REG_LINE_MODE, 32'd1);
    send_item(OP_DATA, 8'h3C);
    send_item(OP_END, 8'h00);
    drain_wait();
  endtask

  task automatic test_output_backpressure();
    rx_free  = 1'b0;
    hold_req = 1'b1;
    send_item(OP_START, 8'($urandom_range(0, 255)));
    repeat (16) send_item(OP_DATA, pick_data());
    send_item(OP_END, 8'($urandom_range(0, 255)));
    // sender pauses here until every result is back
    drain_wait();
  endtask

  task automatic test_random_frames();
    int phase_items;
    int frame_len;
    tx_bursty = 1'b1;
    for (int phase = 0; phase < 5; phase++) begin
      drain_wait();
      case (phase)
        0: begin
          cfg_write(REG_LINE_MODE, 32'd0);
          cfg_write(REG_SCR_SEED, 32'($urandom_range(0, 131071)));
        end
        1: begin
          cfg_write(REG_LINE_MODE, 32'd1);
          cfg_write(REG_SCR_SEED, 32'd0);
        end
        2: cfg_write(REG_SCR_SEED, 32'h1FFFF);
        3: begin
          cfg_write(REG_LINE_MODE, 32'($urandom_range(0, 1)));
          cfg_write(REG_SCR_SEED, 32'($urandom_range(0, 131071)));
        end
        default: begin
          cfg_write(REG_LINE_MODE, 32'd0);
          cfg_write(REG_SCR_SEED, 32'd0);
        end
      endcase
      cfg_read_check(REG_SCR_SEED);
      phase_items = 0;
      while (phase_items < 17) begin
        if ($urandom_range(0, 99) < 15) begin
          send_paced(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          phase_items++;
        end else begin
          frame_len = $urandom_range(0, 6);
          send_paced(OP_START, 8'($urandom_range(0, 255)));
          for (int i = 0; i < frame_len; i++) begin
            if ($urandom_range(0, 9) == 0) send_paced(OP_FLAG, 8'($urandom_range(0, 255)));
            else send_paced(OP_DATA, pick_data());
          end
          send_paced(OP_END, 8'($urandom_range(0, 255)));
          phase_items += frame_len + 2;
        end
      end
    end
    drain_wait();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_ops_without_start();
    test_register_access();
    test_nrzi_frame();
    test_scrambler_frame();
    test_mode_change_mid_frame();
    test_output_backpressure();
    test_random_frames();
    if (expected_out.size() != 0)
      $display("ERROR: %0d expected items never arrived", expected_out.size());
    if (errors == 0 && expected_out.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
